>>> design/amb_pkg.sv
// Shared types and constants for the affine max-bound table.
`timescale 1ns / 1ps
`default_nettype none
package amb_pkg;

    localparam int VALUE_W = 32;
    localparam int ACC_W   = 64;
    localparam int CNT_W   = 7;
    localparam int DIM_W   = 5;
    localparam int EFF_W   = 7;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd1;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] offset;
    } t_in_item;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] result_value;
        logic                      no_pieces;
        logic [CNT_W-1:0]          piece_count;
        logic [CNT_W-1:0]          removed_count;
        logic                      table_full;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_WB,
        S_EVAL,
        S_COPY,
        S_APPEND,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_READ,
        CMD_EXEC,
        CMD_WB,
        CMD_EVAL,
        CMD_COPY,
        CMD_SWEEP_END,
        CMD_APPEND,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic k_done;
        logic last;
        logic act;
        logic need_copy;
        logic i_done;
        logic room;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

>>> design/amb_cfg_if.sv
// Configuration write channel carrying the dimension register.
`timescale 1ns / 1ps
`default_nettype none
interface amb_cfg_if;
    import amb_pkg::*;
    logic             valid;
    logic             ready;
    logic [DIM_W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/amb_in_if.sv
// Input item channel.
`timescale 1ns / 1ps
`default_nettype none
interface amb_in_if;
    import amb_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/amb_out_if.sv
// Result item channel.
`timescale 1ns / 1ps
`default_nettype none
interface amb_out_if;
    import amb_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/affine_max_bound_table.sv
// Top level of the affine max-bound table.
// Items stream one vector element each; the last element of a sequence yields one
// result item. Every item sweeps all stored pieces through the coefficient and
// accumulator memories in read, execute and write-back steps, between an accept
// step and an end-of-sweep step. The last item of a sequence adds an evaluation
// step per piece and a step to load the result register; that step waits while
// the previous result is still held. On an add, each kept piece that moves down
// is copied row by row, and the new row is then appended if the table has room.
// The next item is taken once the current one is done; its result may still wait
// in the output register meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module affine_max_bound_table #(
    parameter int MAX_PIECES    = 64,
    parameter int MAX_DIMENSION = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    amb_cfg_if.sink  i_cfg,
    amb_in_if.sink   i_in,
    amb_out_if.source o_out
);
    import amb_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign i_cfg.ready = 1'b1;

    amb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    amb_datapath #(
        .MAX_PIECES    (MAX_PIECES),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_in.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (o_out.data)
    );

endmodule
`default_nettype wire

>>> design/amb_ctrl.sv
// Sequencer that walks the piece table for each accepted item.
`timescale 1ns / 1ps
`default_nettype none
module amb_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire amb_pkg::t_status i_status,
    output amb_pkg::t_cmd        o_cmd
);
    import amb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: begin
                if (!i_status.k_done) n_state = S_EXEC;
                else if (!i_status.last) n_state = S_IDLE;
                else if (i_status.act) n_state = S_FINISH;
                else if (i_status.room) n_state = S_APPEND;
                else n_state = S_FINISH;
            end
            S_EXEC: n_state = S_WB;
            S_WB: n_state = i_status.last ? S_EVAL : S_READ;
            S_EVAL: n_state = i_status.need_copy ? S_COPY : S_READ;
            S_COPY: begin
                if (i_status.i_done) n_state = S_READ;
            end
            S_APPEND: begin
                if (i_status.i_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = CMD_ACCEPT;
            end
            S_READ: begin
                if (!i_status.k_done) o_cmd = CMD_READ;
                else if (i_status.last && !i_status.act) o_cmd = CMD_SWEEP_END;
            end
            S_EXEC:   o_cmd = CMD_EXEC;
            S_WB:     o_cmd = CMD_WB;
            S_EVAL:   o_cmd = CMD_EVAL;
            S_COPY:   o_cmd = CMD_COPY;
            S_APPEND: o_cmd = CMD_APPEND;
            S_FINISH: begin
                if (!i_status.out_busy) o_cmd = CMD_FINISH;
            end
            default: o_cmd = CMD_NONE;
        endcase
    end

endmodule
`default_nettype wire

>>> design/amb_datapath.sv
// Piece stores, per-piece accumulators, compaction and result register.
`timescale 1ns / 1ps
`default_nettype none
module amb_datapath #(
    parameter int MAX_PIECES    = 64,
    parameter int MAX_DIMENSION = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire amb_pkg::t_cmd    i_cmd,
    output amb_pkg::t_status      o_status,
    input  wire amb_pkg::t_in_item i_item,
    input  wire logic             i_cfg_valid,
    input  wire logic [amb_pkg::DIM_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output amb_pkg::t_out_item    o_out_item
);
    import amb_pkg::*;

    localparam int PW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int CW = $clog2(MAX_PIECES + 1);
    localparam int DW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int IW = $clog2(MAX_DIMENSION + 1);
    localparam int AW = $clog2(MAX_PIECES * MAX_DIMENSION);
    localparam int DEPTH = MAX_PIECES * MAX_DIMENSION;

    logic signed [VALUE_W-1:0] r_coef_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_off_mem  [MAX_PIECES];
    logic signed [ACC_W-1:0]   r_acc_mem  [MAX_PIECES];
    logic signed [VALUE_W-1:0] r_stg_mem  [MAX_DIMENSION];

    logic signed [VALUE_W-1:0] r_coef_rd, r_off_rd, r_stg_rd;
    logic signed [ACC_W-1:0]   r_acc_rd;

    logic [DIM_W-1:0] r_dim;
    logic [DW-1:0]    r_ctr, r_pos;
    logic             r_kind, r_last;
    logic [CW-1:0]    r_count, r_k, r_keep, r_src, r_removed;
    logic [IW-1:0]    r_i;
    logic             r_full, r_any, r_out_valid;
    logic signed [VALUE_W-1:0] r_v, r_off;
    logic signed [ACC_W-1:0]   r_prod, r_newacc, r_best;
    t_out_item        r_out;

    logic [EFF_W-1:0] eff;
    logic [DW-1:0]    n_pos;
    logic             n_last;
    logic [IW-1:0]    i_m1;
    logic             i_done;
    logic signed [VALUE_W:0] diff;
    logic signed [ACC_W-1:0] term, newacc, qval, dval;
    logic             dominated;
    logic [31:0]      sat;

    function automatic logic [AW-1:0] addr(input logic [PW-1:0] row, input logic [DW-1:0] col);
        addr = AW'(row) * AW'(MAX_DIMENSION) + AW'(col);
    endfunction

    always_comb begin
        if (r_dim == '0) eff = EFF_W'(1);
        else if (EFF_W'(r_dim) > EFF_W'(MAX_DIMENSION)) eff = EFF_W'(MAX_DIMENSION);
        else eff = EFF_W'(r_dim);
        n_pos  = (r_ctr != '0 && i_item.action != r_kind) ? '0 : r_ctr;
        n_last = (EFF_W'(n_pos) + EFF_W'(1)) >= eff;
        i_m1   = r_i - IW'(1);
        i_done = r_i == IW'(MAX_DIMENSION);
        diff   = (VALUE_W+1)'(r_v) - (VALUE_W+1)'(r_coef_rd);
        term   = r_kind ? (r_prod >>> 16) : r_prod;
        newacc = ((r_pos == '0) ? '0 : r_acc_rd) + term;
        qval   = r_newacc + ACC_W'(r_off_rd);
        dval   = r_newacc + (ACC_W'(r_off) - ACC_W'(r_off_rd));
        dominated = dval > 0;
        if (r_best > 64'sh7FFF_FFFF) sat = 32'h7FFF_FFFF;
        else if (r_best < -64'sh8000_0000) sat = 32'h8000_0000;
        else sat = r_best[31:0];
    end

    // coefficient store: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_READ) r_coef_rd <= r_coef_mem[addr(r_k[PW-1:0], r_pos)];
        if (i_cmd == CMD_COPY && !i_done) r_coef_rd <= r_coef_mem[addr(r_src[PW-1:0], r_i[DW-1:0])];
        if (i_cmd == CMD_COPY && r_i != '0)
            r_coef_mem[addr(r_keep[PW-1:0], i_m1[DW-1:0])] <= r_coef_rd;
        if (i_cmd == CMD_APPEND && r_i != '0)
            r_coef_mem[addr(r_count[PW-1:0], i_m1[DW-1:0])] <=
                (EFF_W'(i_m1) < eff) ? r_stg_rd : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_READ) r_off_rd <= r_off_mem[r_k[PW-1:0]];
        if (i_cmd == CMD_EVAL && !r_kind && !dominated && r_keep != r_src)
            r_off_mem[r_keep[PW-1:0]] <= r_off_rd;
        if (i_cmd == CMD_APPEND && i_done) r_off_mem[r_count[PW-1:0]] <= r_off;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_READ) r_acc_rd <= r_acc_mem[r_k[PW-1:0]];
        if (i_cmd == CMD_WB) r_acc_mem[r_k[PW-1:0]] <= newacc;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_ACCEPT && i_item.action == KIND_ADD) r_stg_mem[n_pos] <= i_item.value;
        if (i_cmd == CMD_APPEND && !i_done) r_stg_rd <= r_stg_mem[r_i[DW-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim       <= DIM_RESET;
            r_ctr       <= '0;
            r_kind      <= KIND_ADD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_dim <= i_cfg_data;
            if (i_cmd == CMD_ACCEPT) begin
                r_kind <= i_item.action;
                r_ctr  <= n_last ? '0 : n_pos + DW'(1);
            end
            if (i_cmd == CMD_SWEEP_END) r_count <= r_keep;
            if (i_cmd == CMD_APPEND && i_done) r_count <= r_count + CW'(1);
            if (i_cmd == CMD_FINISH) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_ACCEPT: begin
                r_v       <= i_item.value;
                r_off     <= i_item.offset;
                r_pos     <= n_pos;
                r_last    <= n_last;
                r_k       <= '0;
                r_keep    <= '0;
                r_removed <= '0;
                r_any     <= 1'b0;
                r_best    <= '0;
                r_full    <= 1'b0;
            end
            CMD_EXEC: begin
                if (r_kind) r_prod <= ACC_W'(r_v) * ACC_W'(r_coef_rd);
                else r_prod <= (diff > 0) ? '0 : ACC_W'(diff);
            end
            CMD_WB: begin
                r_newacc <= newacc;
                r_src    <= r_k;
                r_k      <= r_k + CW'(1);
            end
            CMD_EVAL: begin
                if (r_kind) begin
                    if (!r_any || qval > r_best) r_best <= qval;
                    r_any <= 1'b1;
                end else if (dominated) begin
                    r_removed <= r_removed + CW'(1);
                end else if (r_keep == r_src) begin
                    r_keep <= r_keep + CW'(1);
                end else begin
                    r_i <= '0;
                end
            end
            CMD_COPY: begin
                if (i_done) r_keep <= r_keep + CW'(1);
                else r_i <= r_i + IW'(1);
            end
            CMD_SWEEP_END: begin
                r_i    <= '0;
                r_full <= !(r_keep < CW'(MAX_PIECES));
            end
            CMD_APPEND: begin
                if (!i_done) r_i <= r_i + IW'(1);
            end
            CMD_FINISH: begin
                r_out.kind          <= r_kind;
                r_out.result_value  <= (r_kind && r_any) ? sat : (r_kind ? 32'h8000_0000 : '0);
                r_out.no_pieces     <= r_kind && !r_any;
                r_out.piece_count   <= CNT_W'(r_count);
                r_out.removed_count <= r_kind ? '0 : CNT_W'(r_removed);
                r_out.table_full    <= r_kind ? 1'b0 : r_full;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.k_done    = r_k >= r_count;
        o_status.last      = r_last;
        o_status.act       = r_kind;
        o_status.need_copy = !r_kind && !dominated && r_keep != r_src;
        o_status.i_done    = i_done;
        o_status.room      = r_keep < CW'(MAX_PIECES);
        o_status.out_busy  = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

>>> design/amb_checker.sv
// Port-level checks for the affine max-bound table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module amb_checker #(
    parameter int MAX_PIECES = 64
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire amb_pkg::t_out_item i_out_data
);
    import amb_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PIECES);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result item changed while stalled");

    a_add_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.kind == KIND_ADD |->
            i_out_data.no_pieces == 1'b0 && i_out_data.result_value == '0)
        else $error("add result carries query fields");

    a_query_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.kind == KIND_QUERY |->
            i_out_data.removed_count == '0 && i_out_data.table_full == 1'b0)
        else $error("query result carries add fields");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.no_pieces |->
            i_out_data.piece_count == '0 && i_out_data.result_value == 32'sh8000_0000)
        else $error("empty query result inconsistent");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.table_full |-> i_out_data.piece_count == FULL_CNT)
        else $error("table full reported below capacity");

endmodule

bind affine_max_bound_table amb_checker #(.MAX_PIECES(MAX_PIECES)) u_amb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the affine max-bound table.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import amb_pkg::*;

    localparam int NPIECE = 64;
    localparam int NDIM   = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count = 0;

    always #10 i_clk = ~i_clk;

    amb_cfg_if cfg_ch();
    amb_in_if  in_ch();
    amb_out_if out_ch();

    affine_max_bound_table dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    class table_scoreboard;
        logic signed [31:0] coef[NPIECE][NDIM];
        logic signed [31:0] offs[NPIECE];
        logic signed [31:0] staged[NDIM];
        longint             acc[NPIECE];
        int                 count;
        int                 elem;
        logic               seq_kind;
        logic [4:0]         dim_reg;
        t_out_item          pending[$];

        function new();
            count = 0; elem = 0; seq_kind = KIND_ADD; dim_reg = DIM_RESET;
            foreach (offs[k]) offs[k] = '0;
            foreach (staged[i]) staged[i] = '0;
            foreach (acc[k]) acc[k] = 0;
            foreach (coef[k, i]) coef[k][i] = '0;
        endfunction

        function automatic longint floor16(longint p);
            return p >>> 16;
        endfunction

        function void note_item(t_in_item it);
            int        dim, pos, keep, removed;
            longint    v, off, term, best, t, c;
            bit        any;
            t_out_item r;
            dim = (dim_reg == 0) ? 1 : (dim_reg > NDIM ? NDIM : dim_reg);
            v = it.value;
            off = it.offset;
            if (elem != 0 && it.action != seq_kind) elem = 0;
            seq_kind = it.action;
            pos = elem % NDIM;
            for (int k = 0; k < count; k++) begin
                c = coef[k][pos];
                if (it.action == KIND_QUERY) term = floor16(v * c);
                else begin
                    term = v - c;
                    if (term > 0) term = 0;
                end
                acc[k] = (pos == 0) ? term : acc[k] + term;
            end
            if (it.action == KIND_ADD) staged[pos] = it.value;
            if (pos + 1 < dim) begin
                elem = pos + 1;
                return;
            end
            elem = 0;
            r = '0;
            r.kind = it.action;
            if (it.action == KIND_QUERY) begin
                any = 0; best = 0;
                for (int k = 0; k < count; k++) begin
                    t = acc[k] + longint'(offs[k]);
                    if (!any || t > best) best = t;
                    any = 1;
                end
                if (!any) best = -64'sd2147483648;
                if (best > 64'sd2147483647) best = 64'sd2147483647;
                if (best < -64'sd2147483648) best = -64'sd2147483648;
                r.result_value = best[31:0];
                r.no_pieces = !any;
                r.piece_count = count[6:0];
            end else begin
                keep = 0; removed = 0;
                for (int k = 0; k < count; k++) begin
                    if (acc[k] + (off - longint'(offs[k])) >= 1) begin
                        removed++;
                        continue;
                    end
                    if (keep != k) begin
                        for (int i = 0; i < NDIM; i++) coef[keep][i] = coef[k][i];
                        offs[keep] = offs[k];
                    end
                    keep++;
                end
                count = keep;
                if (count < NPIECE) begin
                    for (int i = 0; i < NDIM; i++) coef[count][i] = (i < dim) ? staged[i] : '0;
                    offs[count] = it.offset;
                    count++;
                end else r.table_full = 1'b1;
                r.piece_count = count[6:0];
                r.removed_count = removed[6:0];
            end
            pending = {pending, r};
        endfunction

        task check_result(t_out_item got);
            t_out_item w;
            if (pending.size() == 0) begin
                report("unexpected result", got.kind, -1);
                return;
            end
            w = pending.pop_front();
            if (got.kind != w.kind) report("kind", got.kind, w.kind);
            if (got.result_value != w.result_value)
                report("result_value", got.result_value, w.result_value);
            if (got.no_pieces != w.no_pieces) report("no_pieces", got.no_pieces, w.no_pieces);
            if (got.piece_count != w.piece_count)
                report("piece_count", got.piece_count, w.piece_count);
            if (got.removed_count != w.removed_count)
                report("removed_count", got.removed_count, w.removed_count);
            if (got.table_full != w.table_full) report("table_full", got.table_full, w.table_full);
        endtask
    endclass

    table_scoreboard sb = new();
    int  hold_cycles = 0;
    bit  stall_mode = 0;
    bit  stim_done = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
        endcase
    endfunction

    task automatic write_dim(input logic [4:0] d);
        repeat (200) @(negedge i_clk);
        cfg_ch.data <= d;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.dim_reg = d;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // valid stays high after an accept until the next falling edge, where the
    // next item takes over or the channel goes idle
    task automatic send_item(input logic act, input logic signed [31:0] v,
                             input logic signed [31:0] off, input bit no_gap);
        t_in_item it;
        int g;
        g = no_gap ? 0 : gap_len();
        @(negedge i_clk);
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        it.action = act; it.value = v; it.offset = off;
        in_ch.data <= it;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(it);
    endtask

    task automatic send_seq(input logic act, input int n, input bit no_gap);
        for (int i = 0; i < n; i++) send_item(act, rand_val(), rand_val(), no_gap);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // receiver
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else if (stall_mode && $urandom_range(0, 99) < 4) begin
            hold_cycles <= $urandom_range(10, 50);
            out_ch.ready <= 1'b0;
        end else out_ch.ready <= stall_mode ? ($urandom_range(0, 99) < 70) : 1'b1;
    end

    always @(posedge i_clk)
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);

    initial begin
        in_ch.valid = 1'b0; in_ch.data = '0;
        cfg_ch.valid = 1'b0; cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // empty query, then extremes at dimension 1
        send_item(KIND_QUERY, 32'sh7fffffff, 0, 1);
        send_item(KIND_ADD, 32'sh80000000, 32'sh80000000, 1);
        send_item(KIND_ADD, 32'sh7fffffff, 32'sh7fffffff, 1);
        send_item(KIND_QUERY, 32'sh80000000, 32'sh7fffffff, 1);
        send_item(KIND_QUERY, 32'sh7fffffff, 0, 1);
        send_item(KIND_ADD, 32'sh00010000, 32'sh00000001, 1);
        send_item(KIND_QUERY, 32'shffffffff, 0, 1);
        drain();
        write_dim(5'd16);
        send_seq(KIND_ADD, 16, 1);
        send_seq(KIND_ADD, 7, 1);       // abandoned by the query
        send_seq(KIND_QUERY, 16, 1);
        send_seq(KIND_ADD, 3, 1);       // left open across a register change
        drain();
        write_dim(5'd2);
        send_seq(KIND_ADD, 2, 1);
        drain();
        write_dim(5'd0);
        send_seq(KIND_ADD, 1, 1);
        send_seq(KIND_QUERY, 1, 1);
        drain();
        write_dim(5'd31);
        send_seq(KIND_QUERY, 16, 1);
        drain();
        // random phases
        stall_mode = 1;
        for (int ph = 0; ph < 6; ph++) begin
            int d;
            d = (ph == 0) ? 1 : (ph == 5 ? 31 : $urandom_range(0, 31));
            write_dim(d[4:0]);
            if (d == 0) d = 1;
            if (d > 16) d = 16;
            for (int n = 0; n < 80 / d + 2; n++) begin
                if ($urandom_range(0, 9) == 0) send_seq($urandom_range(0, 1), $urandom_range(1, d), 0);
                else send_seq(n % 3 == 2 ? KIND_QUERY : KIND_ADD, d, 0);
                if (n == 5) begin
                    hold_cycles = 3000;
                end
            end
            drain();
        end
        // fill the table with pieces that never dominate each other
        write_dim(5'd1);
        for (int n = 0; n < 70; n++)
            send_item(KIND_ADD, 32'sh00010000 * n, 32'sh7fffffff - n * 32'sh1000, 0);
        send_item(KIND_QUERY, 32'sh00000100, 0, 0);
        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        repeat (3000) @(posedge i_clk);
        if (sb.pending.size() != 0) report("results left over", sb.pending.size(), 0);
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
design/amb_pkg.sv
design/amb_cfg_if.sv
design/amb_in_if.sv
design/amb_out_if.sv
design/amb_ctrl.sv
design/amb_datapath.sv
design/affine_max_bound_table.sv
design/amb_checker.sv
tb/tb.sv
